// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the capture FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("capture fifo check failed");

// Consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("capture fifo check failed");

// Consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("capture fifo check failed");

`endif

// ----- hdl/acrf_pkg.sv -----
// Shared types, constants and helper functions of the audio capture ring FIFO.
package acrf_pkg;

	localparam int RING_FRAMES  = 4096;
	localparam int MAX_CHANNELS = 8;

	localparam int PTR_W      = $clog2(RING_FRAMES);
	localparam int CNT_W      = $clog2(RING_FRAMES + 1);
	localparam int CH_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CH_W       = 4;
	localparam int BLK_W      = 16;
	localparam int SAMPLE_W   = 24;
	localparam int PEAK_W     = 23;
	localparam int OVR_W      = 32;
	localparam int CMP_W      = ((BLK_W > CNT_W) ? BLK_W : CNT_W) + 1;

	localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

	// Stream packing
	localparam int IN_RAW_W     = BLK_W + CH_W + MAX_CHANNELS * SAMPLE_W;
	localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W    = MAX_CHANNELS * SAMPLE_W + PEAK_W + OVR_W + CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_TUSER_W  = 1;

	// Output queue and credit counter
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_OUT_CHANNELS = 3'd0;

	// Item kinds on tuser bit 0
	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] acrf_frame_t;
	typedef logic [MAX_CHANNELS-1:0][PEAK_W-1:0]   acrf_mags_t;

	// Ring access for the current beat
	typedef struct packed {
		logic             wr_en;
		logic [PTR_W-1:0] wr_addr;
		logic             rd_en;
		logic [PTR_W-1:0] rd_addr;
	} acrf_ctl_t;

	// Status of a beat after its control update
	typedef struct packed {
		logic             vld;
		logic             frame_valid;
		logic [OVR_W-1:0] overrun;
		logic [CNT_W-1:0] fill;
	} acrf_stat_t;

	// One result beat
	typedef struct packed {
		logic [CNT_W-1:0]  fill;
		logic [OVR_W-1:0]  overrun;
		logic [PEAK_W-1:0] peak;
		acrf_frame_t       samples;
		logic              frame_valid;
	} acrf_res_t;

	// Clamp a channel count to 1..MAX_CHANNELS
	function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] v);
		logic [CH_W-1:0] r;
		if (v == '0) begin
			r = CH_W'(1);
		end else if (v > CH_W'(MAX_CHANNELS)) begin
			r = CH_W'(MAX_CHANNELS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Absolute value of a Q1.23 sample, most negative saturates
	function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] neg;
		logic [PEAK_W-1:0]   r;
		neg = ~s + SAMPLE_W'(1);
		if (!s[SAMPLE_W-1]) begin
			r = s[PEAK_W-1:0];
		end else if (s[PEAK_W-1:0] == '0) begin
			r = PEAK_MAX;
		end else begin
			r = neg[PEAK_W-1:0];
		end
		return r;
	endfunction

	// Advance a ring position with wrap
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_FRAMES - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

// ----- hdl/audio_capture_ring_fifo.sv -----
// An accepted beat passes stat_s1, stat_s2 and the result queue to the master.
// Throughput: one beat per cycle while results are taken; a 4-entry result queue
//   with a credit counter covering the two pipeline stages sets this figure.
// Reset: ring positions, fill, block state, peak, overrun count and the queue
//   clear at once; out_channels returns to 1. Ring memory is not cleared.
`include "assert_macros.svh"
module audio_capture_ring_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [acrf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [acrf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [acrf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// Input beats
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// block_frames, src_channels, in_sample_0..7, zero pad
	input  logic [acrf_pkg::IN_TDATA_W-1:0]     s_tdata,
	// func, first_frame
	input  logic [acrf_pkg::IN_TUSER_W-1:0]     s_tuser,
	// Result beats
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_sample_0..7, peak_level, overrun_count, fill_frames, zero pad
	output logic [acrf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// frame_valid
	output logic [acrf_pkg::OUT_TUSER_W-1:0]    m_tuser
);
	import acrf_pkg::*;

	logic [CH_W-1:0]    oc_q;
	logic [CH_W-1:0]    oc_cl;
	logic [CH_W-1:0]    sc_cl;
	logic               apb_wr;
	logic               acc;
	logic               m_pop;
	logic [BLK_W-1:0]   blk;
	acrf_frame_t        in_samples;
	acrf_ctl_t          ctl;
	acrf_stat_t         stat_s1;
	acrf_mags_t         mag_s1;
	acrf_frame_t        rd_s1;
	logic               res_vld;
	acrf_res_t          res;
	acrf_res_t          q_mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] q_wp_q, q_rp_q;
	logic [Q_CNT_W-1:0] q_cnt_q;
	logic [Q_CNT_W-1:0] total_q;

	// Configuration register
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == REG_OUT_CHANNELS) ? APB_DATA_W'(oc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q <= CH_W'(1);
		end else if (apb_wr && paddr == REG_OUT_CHANNELS) begin
			oc_q <= pwdata[CH_W-1:0];
		end
	end

	// Unpack the input beat
	assign blk        = s_tdata[BLK_W-1:0];
	assign sc_cl      = clamp_ch(s_tdata[BLK_W +: CH_W]);
	assign in_samples = s_tdata[BLK_W + CH_W +: MAX_CHANNELS * SAMPLE_W];
	assign oc_cl      = clamp_ch(oc_q);

	// Accept while a queue slot is free for every beat in flight
	assign s_tready = total_q < Q_CNT_W'(Q_DEPTH);
	assign acc      = s_tvalid && s_tready;
	assign m_pop    = m_tvalid && m_tready;

	acrf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.func    (s_tuser[0]),
		.first   (s_tuser[1]),
		.blk     (blk),
		.ctl     (ctl),
		.stat_s1 (stat_s1)
	);

	for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
		acrf_lane u_lane (
			.clk      (clk),
			.lane_idx (CH_IDX_W'(g)),
			.ctl      (ctl),
			.samples  (in_samples),
			.src_ch   (sc_cl),
			.out_ch   (oc_cl),
			.mag_s1   (mag_s1[g]),
			.rd_s1    (rd_s1[g])
		);
	end

	acrf_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat_s1 (stat_s1),
		.mag_s1  (mag_s1),
		.rd_s1   (rd_s1),
		.out_ch  (oc_cl),
		.res_vld (res_vld),
		.res     (res)
	);

	// Result queue storage
	always_ff @(posedge clk) begin
		if (res_vld) begin
			q_mem[q_wp_q] <= res;
		end
	end

	// Queue pointers and the credit count of beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q  <= '0;
			q_rp_q  <= '0;
			q_cnt_q <= '0;
			total_q <= '0;
		end else begin
			if (res_vld) begin
				q_wp_q <= q_wp_q + Q_PTR_W'(1);
			end
			if (m_pop) begin
				q_rp_q <= q_rp_q + Q_PTR_W'(1);
			end
			if (res_vld && !m_pop) begin
				q_cnt_q <= q_cnt_q + Q_CNT_W'(1);
			end else if (!res_vld && m_pop) begin
				q_cnt_q <= q_cnt_q - Q_CNT_W'(1);
			end
			if (acc && !m_pop) begin
				total_q <= total_q + Q_CNT_W'(1);
			end else if (!acc && m_pop) begin
				total_q <= total_q - Q_CNT_W'(1);
			end
		end
	end

	// Present the head of the queue
	assign m_tvalid = q_cnt_q != '0;
	assign m_tdata  = OUT_TDATA_W'({q_mem[q_rp_q].fill, q_mem[q_rp_q].overrun,
		q_mem[q_rp_q].peak, q_mem[q_rp_q].samples});
	assign m_tuser  = OUT_TUSER_W'(q_mem[q_rp_q].frame_valid);

	`ASSERT_ALWAYS(a_credit_max, total_q <= Q_CNT_W'(Q_DEPTH))
	`ASSERT_ALWAYS(a_queue_in_credit, q_cnt_q <= total_q)
	`ASSERT_IMPL(a_queue_room, res_vld, q_cnt_q < Q_CNT_W'(Q_DEPTH))
	`ASSERT_NEXT(a_cfg_write, apb_wr && paddr == REG_OUT_CHANNELS, oc_q == $past(pwdata[CH_W-1:0]))

endmodule

// ----- hdl/acrf_lane.sv -----
// One channel lane: source remap, sample magnitude and the channel's slice of the ring.
module acrf_lane (
	input  logic                          clk,
	input  logic [acrf_pkg::CH_IDX_W-1:0] lane_idx,
	input  acrf_pkg::acrf_ctl_t           ctl,
	input  acrf_pkg::acrf_frame_t         samples,
	input  logic [acrf_pkg::CH_W-1:0]     src_ch,
	input  logic [acrf_pkg::CH_W-1:0]     out_ch,
	output logic [acrf_pkg::PEAK_W-1:0]   mag_s1,
	output logic [acrf_pkg::SAMPLE_W-1:0] rd_s1
);
	import acrf_pkg::*;

	logic [SAMPLE_W-1:0] mem [RING_FRAMES];
	logic [CH_IDX_W-1:0] src_sel;
	logic [SAMPLE_W-1:0] wdata;
	logic                used;

	// Pick own source channel, else repeat the last source channel
	always_comb begin
		if (CH_W'(lane_idx) < src_ch) begin
			src_sel = lane_idx;
		end else begin
			src_sel = CH_IDX_W'(src_ch - CH_W'(1));
		end
		used  = CH_W'(lane_idx) < out_ch;
		wdata = used ? samples[src_sel] : '0;
	end

	// Write the stored sample, read the drained one
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_s1 <= mem[ctl.rd_addr];
		end
	end

	// Register magnitude of a stored sample, zero otherwise
	always_ff @(posedge clk) begin
		mag_s1 <= (ctl.wr_en && used) ? magnitude(wdata) : '0;
	end

endmodule

// ----- hdl/acrf_ctrl.sv -----
// Block admission, ring positions, fill level and overrun counter.
`include "assert_macros.svh"
module acrf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic                       func,
	input  logic                       first,
	input  logic [acrf_pkg::BLK_W-1:0] blk,
	output acrf_pkg::acrf_ctl_t        ctl,
	output acrf_pkg::acrf_stat_t       stat_s1
);
	import acrf_pkg::*;

	logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [BLK_W-1:0] rem_q, rem_d;
	logic             drop_q, drop_d;
	logic [OVR_W-1:0] ovr_q, ovr_d;
	logic [CNT_W-1:0] free;
	logic             too_big;
	logic             room;
	logic             store;
	logic             drain;

	// Decide admission and the ring access for this beat
	always_comb begin
		free    = CNT_W'(RING_FRAMES) - held_q;
		too_big = CMP_W'(blk) > CMP_W'(free);
		room    = held_q < CNT_W'(RING_FRAMES);
		rem_d   = rem_q;
		drop_d  = drop_q;
		ovr_d   = ovr_q;
		store   = 1'b0;
		drain   = 1'b0;
		if (acc) begin
			if (func == FUNC_PUSH) begin
				if (first) begin
					if (blk == '0) begin
						rem_d  = '0;
						drop_d = 1'b0;
					end else if (too_big) begin
						if (ovr_q != '1) begin
							ovr_d = ovr_q + OVR_W'(1);
						end
						drop_d = 1'b1;
						rem_d  = blk - BLK_W'(1);
					end else begin
						drop_d = 1'b0;
						rem_d  = blk - BLK_W'(1);
						store  = room;
					end
				end else if (rem_q != '0) begin
					rem_d = rem_q - BLK_W'(1);
					store = !drop_q && room;
				end
			end else begin
				drain = held_q != '0;
			end
		end
		wr_ptr_d = store ? next_ptr(wr_ptr_q) : wr_ptr_q;
		rd_ptr_d = drain ? next_ptr(rd_ptr_q) : rd_ptr_q;
		if (store) begin
			held_d = held_q + CNT_W'(1);
		end else if (drain) begin
			held_d = held_q - CNT_W'(1);
		end else begin
			held_d = held_q;
		end
	end

	assign ctl.wr_en   = store;
	assign ctl.wr_addr = wr_ptr_q;
	assign ctl.rd_en   = drain;
	assign ctl.rd_addr = rd_ptr_q;

	// Hold control state and the status travelling with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q            <= '0;
			rd_ptr_q            <= '0;
			held_q              <= '0;
			rem_q               <= '0;
			drop_q              <= 1'b0;
			ovr_q               <= '0;
			stat_s1.vld         <= 1'b0;
			stat_s1.frame_valid <= 1'b0;
			stat_s1.overrun     <= '0;
			stat_s1.fill        <= '0;
		end else begin
			wr_ptr_q            <= wr_ptr_d;
			rd_ptr_q            <= rd_ptr_d;
			held_q              <= held_d;
			rem_q               <= rem_d;
			drop_q              <= drop_d;
			ovr_q               <= ovr_d;
			stat_s1.vld         <= acc;
			stat_s1.frame_valid <= drain;
			stat_s1.overrun     <= ovr_d;
			stat_s1.fill        <= held_d;
		end
	end

	`ASSERT_ALWAYS(a_held_max, held_q <= CNT_W'(RING_FRAMES))
	`ASSERT_IMPL(a_empty_ptrs, held_q == '0, wr_ptr_q == rd_ptr_q)
	`ASSERT_NEXT(a_store_grows, store, held_q == $past(held_q) + CNT_W'(1))

endmodule

// ----- hdl/acrf_merge.sv -----
// Merge of the lanes: peak over lane magnitudes and assembly of the result beat.
module acrf_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  acrf_pkg::acrf_stat_t        stat_s1,
	input  acrf_pkg::acrf_mags_t        mag_s1,
	input  acrf_pkg::acrf_frame_t       rd_s1,
	input  logic [acrf_pkg::CH_W-1:0]   out_ch,
	output logic                        res_vld,
	output acrf_pkg::acrf_res_t         res
);
	import acrf_pkg::*;

	localparam int HALF = (MAX_CHANNELS + 1) / 2;

	acrf_stat_t        stat_s2;
	acrf_frame_t       samp_d, samp_s2;
	logic [PEAK_W-1:0] max_a_d, max_b_d, max_a_s2, max_b_s2;
	logic [PEAK_W-1:0] pair_max;
	logic [PEAK_W-1:0] peak_q, peak_d;

	// Mask drained channels and reduce each half of the lanes
	always_comb begin
		max_a_d = '0;
		max_b_d = '0;
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			samp_d[c] = (stat_s1.frame_valid && CH_W'(c) < out_ch) ? rd_s1[c] : '0;
			if (c < HALF) begin
				if (mag_s1[c] > max_a_d) max_a_d = mag_s1[c];
			end else begin
				if (mag_s1[c] > max_b_d) max_b_d = mag_s1[c];
			end
		end
	end

	// Fold the two halves into the running peak
	always_comb begin
		pair_max = (max_a_s2 > max_b_s2) ? max_a_s2 : max_b_s2;
		peak_d   = (pair_max > peak_q) ? pair_max : peak_q;
	end

	// Advance the status stage and hold the running peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_s2.vld         <= 1'b0;
			stat_s2.frame_valid <= 1'b0;
			stat_s2.overrun     <= '0;
			stat_s2.fill        <= '0;
			peak_q              <= '0;
		end else begin
			stat_s2.vld         <= stat_s1.vld;
			stat_s2.frame_valid <= stat_s1.frame_valid;
			stat_s2.overrun     <= stat_s1.overrun;
			stat_s2.fill        <= stat_s1.fill;
			if (stat_s2.vld) begin
				peak_q <= peak_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		samp_s2  <= samp_d;
		max_a_s2 <= max_a_d;
		max_b_s2 <= max_b_d;
	end

	assign res_vld         = stat_s2.vld;
	assign res.fill        = stat_s2.fill;
	assign res.overrun     = stat_s2.overrun;
	assign res.peak        = peak_d;
	assign res.samples     = samp_s2;
	assign res.frame_valid = stat_s2.frame_valid;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the audio capture ring FIFO: block admission, remap, drain, status.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import acrf_pkg::*;

	localparam int SMP_BITS       = SAMPLE_W * MAX_CHANNELS;
	localparam int TIMEOUT_CYCLES = 1500000;
	localparam int REPORT_CAP     = 60;
	localparam int PRESSURE_HOLD  = 250;
	localparam int PHASES         = 6;
	localparam int PHASE_BEATS    = 260;
	localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
	localparam logic [SAMPLE_W-1:0]   MOST_NEG      = 24'h800000;
	localparam logic [SAMPLE_W-1:0]   MOST_POS      = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0]   MINUS_ONE     = 24'hFFFFFF;

	// One input beat before packing
	typedef struct packed {
		logic              func;
		logic              first;
		logic [BLK_W-1:0]  nfr;
		logic [CH_W-1:0]   src;
		acrf_frame_t       smp;
	} capture_item_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata  = '0;	// block_frames, src_channels, in_sample_0..7
	logic [IN_TUSER_W-1:0] s_tuser  = '0;	// func, first_frame
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;	// out_sample_0..7, peak_level, overrun_count, fill_frames
	logic [OUT_TUSER_W-1:0] m_tuser;	// frame_valid

	audio_capture_ring_fifo dut (.*);

	// Mirror of the ring and its status
	acrf_frame_t       ring_mem [RING_FRAMES];
	int unsigned       wr_pos    = 0;
	int unsigned       rd_pos    = 0;
	int unsigned       held_cnt  = 0;
	int unsigned       blk_left  = 0;
	logic              blk_drop  = 1'b0;
	logic [PEAK_W-1:0] peak_lvl  = '0;
	logic [OVR_W-1:0]  drop_cnt  = '0;
	logic [CH_W-1:0]   chan_cfg  = 4'd1;
	int unsigned       fill_high = 0;

	// Stimulus and scoreboard bookkeeping
	capture_item_t beats_pending [$];
	acrf_res_t     ring_results_due [$];
	capture_item_t beat_now;
	acrf_res_t     want;
	acrf_res_t     got;
	int unsigned   queued_cnt   = 0;
	int unsigned   accepted_cnt = 0;
	int unsigned   results_seen = 0;
	int unsigned   drained_cnt  = 0;
	int unsigned   fail_cnt     = 0;
	int unsigned   amp_bits     = 6;
	int unsigned   src_idle_pct = 0;
	int unsigned   snk_idle_pct = 0;
	int unsigned   src_gap      = 0;
	int unsigned   snk_gap      = 0;
	int unsigned   hold_left    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned chan_limit(input logic [CH_W-1:0] v);
		if (v == '0) return 1;
		if (v > CH_W'(MAX_CHANNELS)) return MAX_CHANNELS;
		return 32'(v);
	endfunction

	// Absolute value, with the most negative code pinned to full scale
	function automatic logic [PEAK_W-1:0] abs_level(input logic [SAMPLE_W-1:0] s);
		int v;
		v = int'($signed(s));
		if (v < 0) v = -v;
		if (v > int'(PEAK_MAX)) v = int'(PEAK_MAX);
		return v[PEAK_W-1:0];
	endfunction

	// Remap one source frame into the ring and update the peak
	function automatic void store_frame(input capture_item_t it);
		int unsigned oc;
		int unsigned sc;
		int unsigned pick;
		acrf_frame_t fr;
		oc = chan_limit(chan_cfg);
		sc = chan_limit(it.src);
		fr = '0;
		if (held_cnt >= RING_FRAMES) return;
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			if (c < oc) begin
				pick = (c < sc) ? c : sc - 1;
				fr[c] = it.smp[pick];
				if (abs_level(fr[c]) > peak_lvl) peak_lvl = abs_level(fr[c]);
			end
		end
		ring_mem[wr_pos] = fr;
		wr_pos = (wr_pos == RING_FRAMES - 1) ? 0 : wr_pos + 1;
		held_cnt++;
		if (held_cnt > fill_high) fill_high = held_cnt;
	endfunction

	// Advance the mirror by one accepted beat and return the status beat it causes
	function automatic acrf_res_t predict_ring_result(input capture_item_t it);
		acrf_res_t r;
		int unsigned oc;
		r = '0;
		if (it.func == FUNC_PUSH) begin
			if (it.first) begin
				if (it.nfr == '0) begin
					blk_left = 0;
					blk_drop = 1'b0;
				end else if (32'(it.nfr) > RING_FRAMES - held_cnt) begin
					if (drop_cnt != '1) drop_cnt++;
					blk_drop = 1'b1;
					blk_left = 32'(it.nfr) - 1;
				end else begin
					blk_drop = 1'b0;
					blk_left = 32'(it.nfr) - 1;
					store_frame(it);
				end
			end else if (blk_left != 0) begin
				blk_left--;
				if (!blk_drop) store_frame(it);
			end
		end else if (held_cnt != 0) begin
			oc = chan_limit(chan_cfg);
			r.frame_valid = 1'b1;
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				if (c < oc) r.samples[c] = ring_mem[rd_pos][c];
			end
			rd_pos = (rd_pos == RING_FRAMES - 1) ? 0 : rd_pos + 1;
			held_cnt--;
		end
		r.peak    = peak_lvl;
		r.overrun = drop_cnt;
		r.fill    = held_cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic void report_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			fail_cnt++;
			if (fail_cnt <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
		end
	endfunction

	// Random sample, scaled to the current amplitude; zero width means full range
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int v;
		if (amp_bits == 0) begin
			case ($urandom_range(0, 7))
				0: return MOST_NEG;
				1: return MOST_POS;
				2: return '0;
				3: return MINUS_ONE;
				default: return SAMPLE_W'($urandom);
			endcase
		end
		v = $urandom_range(0, (1 << (amp_bits + 1)) - 1) - (1 << amp_bits);
		return v[SAMPLE_W-1:0];
	endfunction

	// Mostly legal channel counts, sometimes zero or above the maximum
	function automatic logic [CH_W-1:0] pick_src();
		logic [CH_W-1:0] r;
		if ($urandom_range(0, 9) != 0) begin
			r = CH_W'($urandom_range(1, MAX_CHANNELS));
		end else if ($urandom_range(0, 1) == 0) begin
			r = '0;
		end else begin
			r = CH_W'($urandom_range(MAX_CHANNELS + 1, (1 << CH_W) - 1));
		end
		return r;
	endfunction

	function automatic capture_item_t make_beat(input logic func, input logic first,
			input logic [BLK_W-1:0] nfr, input logic [CH_W-1:0] src);
		capture_item_t it;
		it.func  = func;
		it.first = first;
		it.nfr   = nfr;
		it.src   = src;
		for (int c = 0; c < MAX_CHANNELS; c++) it.smp[c] = pick_sample();
		return it;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_beat(input capture_item_t it);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[IN_RAW_W-1:0] = {it.smp, it.src, it.nfr};
		return d;
	endfunction

	function automatic void queue_beat(input capture_item_t it);
		beats_pending.push_back(it);
		queued_cnt++;
	endfunction

	function automatic void push_frame(input logic first, input logic [BLK_W-1:0] nfr);
		queue_beat(make_beat(FUNC_PUSH, first, nfr, pick_src()));
	endfunction

	function automatic void queue_drain();
		queue_beat(make_beat(FUNC_DRAIN, 1'($urandom_range(0, 1)), BLK_W'($urandom),
			pick_src()));
	endfunction

	// Mostly well-formed blocks and drains, the rest oversized, empty and stray frames
	function automatic void queue_random(input int unsigned target);
		int unsigned done_cnt;
		int unsigned pick;
		int unsigned n;
		done_cnt = 0;
		while (done_cnt < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				push_frame(1'b1, n[BLK_W-1:0]);
				done_cnt++;
				for (int k = 1; k < n; k++) begin
					if ($urandom_range(0, 19) == 0) break;
					if ($urandom_range(0, 4) == 0) begin
						queue_drain();
						done_cnt++;
					end
					push_frame(1'b0, BLK_W'($urandom));
					done_cnt++;
				end
			end else if (pick < 85) begin
				n = $urandom_range(1, 8);
				repeat (n) queue_drain();
				done_cnt += n;
			end else if (pick < 92) begin
				n = $urandom_range(0, 1) ? $urandom_range(RING_FRAMES + 1, 65535) : RING_FRAMES;
				push_frame(1'b1, n[BLK_W-1:0]);
				repeat ($urandom_range(0, 4)) push_frame(1'b0, BLK_W'($urandom));
				done_cnt++;
			end else if (pick < 95) begin
				push_frame(1'b1, '0);
				repeat ($urandom_range(0, 2)) push_frame(1'b0, BLK_W'($urandom));
			end else begin
				repeat ($urandom_range(1, 3)) push_frame(1'b0, BLK_W'($urandom));
			end
		end
	endfunction

	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write out_channels, poke the unmapped slot, read the register back
	task automatic set_channels(input logic [CH_W-1:0] val);
		logic [APB_DATA_W-1:0] wdata;
		logic [APB_DATA_W-1:0] rdata;
		wdata = {{(APB_DATA_W - CH_W){1'b0}}, val};
		if ($urandom_range(0, 1) != 0)
			wdata[APB_DATA_W-1:CH_W] = (APB_DATA_W - CH_W)'($urandom);
		apb_access(1'b1, REG_OUT_CHANNELS, wdata, rdata);
		chan_cfg = val;
		apb_access(1'b1, UNMAPPED_ADDR, $urandom, rdata);
		apb_access(1'b0, REG_OUT_CHANNELS, '0, rdata);
		report_field("out_channels readback", {{(APB_DATA_W - CH_W){1'b0}}, val}, rdata);
	endtask

	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || ring_results_due.size() != 0) @(posedge clk);
	endtask

	// Source side: offer pending beats, with random idle bursts between them
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				ring_results_due.push_back(predict_ring_result(beat_now));
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (beats_pending.size() != 0 && src_idle_pct != 0 &&
						$urandom_range(0, 99) < src_idle_pct) begin
					src_gap = $urandom_range(1, 19) - 1;
					s_tvalid <= 1'b0;
				end else if (beats_pending.size() != 0) begin
					beat_now = beats_pending.pop_front();
					s_tdata  <= pack_beat(beat_now);
					s_tuser  <= {beat_now.first, beat_now.func};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: check each beat against the oldest prediction, pace tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.frame_valid = m_tuser[0];
				got.samples     = m_tdata[SMP_BITS-1:0];
				got.peak        = m_tdata[SMP_BITS +: PEAK_W];
				got.overrun     = m_tdata[SMP_BITS + PEAK_W +: OVR_W];
				got.fill        = m_tdata[SMP_BITS + PEAK_W + OVR_W +: CNT_W];
				results_seen++;
				if (ring_results_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_CAP)
						$display("%0t: result beat with nothing expected, actual %0h",
							$time, m_tdata);
				end else begin
					want = ring_results_due.pop_front();
					report_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
					for (int c = 0; c < MAX_CHANNELS; c++)
						report_field($sformatf("out_sample_%0d", c), 32'(want.samples[c]),
							32'(got.samples[c]));
					report_field("peak_level", 32'(want.peak), 32'(got.peak));
					report_field("overrun_count", want.overrun, got.overrun);
					report_field("fill_frames", 32'(want.fill), 32'(got.fill));
					if (want.frame_valid) drained_cnt++;
				end
				// long hold-off so the result queue backs up into the input
				if (results_seen == 400 || results_seen == 2500) hold_left = PRESSURE_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
				snk_gap = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still due", cycles,
			ring_results_due.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		capture_item_t   it;
		logic [CH_W-1:0] chan_plan [PHASES];
		int unsigned     amp_plan [PHASES];
		int unsigned     src_plan [PHASES];
		int unsigned     snk_plan [PHASES];
		chan_plan = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd2, 4'd7};
		chan_plan[4] = CH_W'($urandom_range(2, 7));
		chan_plan[5] = CH_W'($urandom_range(2, 7));
		amp_plan  = '{8, 11, 14, 17, 20, 21};
		src_plan  = '{0, 10, 30, 5, 20, 10};
		snk_plan  = '{0, 20, 10, 30, 5, 15};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: status corner cases at the reset channel count
		amp_bits     = 6;
		src_idle_pct = 10;
		snk_idle_pct = 10;
		queue_beat(make_beat(FUNC_DRAIN, 1'b0, '0, 4'd1));			// drain of an empty ring
		queue_beat(make_beat(FUNC_PUSH, 1'b0, 16'd5, 4'd2));		// stray frame
		queue_beat(make_beat(FUNC_PUSH, 1'b1, 16'd0, 4'd8));		// empty block
		queue_beat(make_beat(FUNC_PUSH, 1'b1, BLK_W'(RING_FRAMES), 4'd8));	// fills free space
		queue_beat(make_beat(FUNC_PUSH, 1'b0, BLK_W'($urandom), 4'd0));	// zero channels as one
		queue_beat(make_beat(FUNC_PUSH, 1'b1, BLK_W'(RING_FRAMES - 2), 4'd3));	// new block
		queue_beat(make_beat(FUNC_PUSH, 1'b1, BLK_W'(RING_FRAMES - 2), 4'd3));	// one too many
		queue_beat(make_beat(FUNC_PUSH, 1'b0, BLK_W'($urandom), 4'd3));	// dropped block frame
		queue_drain();
		queue_beat(make_beat(FUNC_PUSH, 1'b1, 16'hFFFF, 4'd5));	// largest block: dropped
		queue_beat(make_beat(FUNC_PUSH, 1'b1, 16'd1, 4'd15));		// too many channels act as max
		queue_beat(make_beat(FUNC_PUSH, 1'b0, BLK_W'($urandom), 4'd4));	// past the block's end
		repeat (4) queue_drain();
		wait_idle();

		// Random phases, each at its own channel count, amplitude and pacing
		for (int ph = 0; ph < PHASES; ph++) begin
			amp_bits     = amp_plan[ph];
			src_idle_pct = src_plan[ph];
			snk_idle_pct = snk_plan[ph];
			set_channels(chan_plan[ph]);
			queue_random(PHASE_BEATS);
			wait_idle();
		end

		// Last stretch without idling: full-scale samples, then full-range random
		src_idle_pct = 0;
		snk_idle_pct = 0;
		amp_bits     = 0;
		set_channels(CH_W'($urandom_range(1, MAX_CHANNELS)));
		it = make_beat(FUNC_PUSH, 1'b1, 16'd2, 4'd8);
		it.smp = {MAX_CHANNELS{MOST_NEG}};
		queue_beat(it);
		it = make_beat(FUNC_PUSH, 1'b0, 16'd0, 4'd8);
		it.smp = {MAX_CHANNELS{MOST_POS}};
		queue_beat(it);
		queue_drain();
		queue_drain();
		queue_random(60);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Covered %0d input beats over %0d channel settings, %0d frames drained.",
			accepted_cnt, PHASES + 2, drained_cnt);
		$display("Ring reached %0d of %0d frames; %0d blocks dropped; final peak %0h.",
			fill_high, RING_FRAMES, drop_cnt, peak_lvl);
		if (ring_results_due.size() != 0)
			$display("%0d expected results never arrived", ring_results_due.size());
		if (fail_cnt == 0 && ring_results_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
